### hdl/vog_pkg.sv
// Shared types and constants for the voxel occupancy grid.
// Grid limits, field widths, action and register codes, and the control structs.
`timescale 1ns / 1ps
`default_nettype none

package vog_pkg;

  // Grid limits
  localparam int MAX_LENGTH = 64;
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 16;

  // Fixed field widths
  localparam int CFG_LEN_W  = 7;
  localparam int CFG_WID_W  = 7;
  localparam int CFG_HGT_W  = 5;
  localparam int SCALE_W    = 16;
  localparam int POS_W      = 32;
  localparam int QCELL_W    = 16;
  localparam int OUT_CELL_W = 16;
  localparam int LIN_W      = 16;
  localparam int ACT_W      = 2;
  localparam int DIFF_W     = POS_W + 1;
  localparam int PROD_W     = DIFF_W + SCALE_W + 1;
  localparam int FRAC_W     = 24;
  localparam int CELL_W     = PROD_W - FRAC_W;

  // Configuration port
  localparam int APB_DW   = 32;
  localparam int PADDR_W  = 5;
  localparam int REG_IDX_W = 3;

  // Reset values of the configuration registers
  localparam int RST_LENGTH = 64;
  localparam int RST_WIDTH  = 64;
  localparam int RST_HEIGHT = 16;
  localparam int RST_SCALE  = 256;

  // Widths that follow from the grid limits
  localparam int LEN_W = $clog2(MAX_LENGTH + 1);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int XC_W  = $clog2(MAX_LENGTH);
  localparam int YC_W  = $clog2(MAX_WIDTH);
  localparam int ZC_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Occupancy store layout: rows of up to 64 bits
  localparam int CELLS    = MAX_LENGTH * MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W    = $clog2(CELLS);
  localparam int ROW_LOG  = (IDX_W < 6) ? IDX_W : 6;
  localparam int ROW_BITS = 1 << ROW_LOG;
  localparam int ROWS     = (CELLS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [ACT_W-1:0] {
    ACT_QUERY_POS  = 2'd0,
    ACT_QUERY_CELL = 2'd1,
    ACT_SET        = 2'd2,
    ACT_CLEAR      = 2'd3
  } act_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LENGTH = 3'd0,
    REG_WIDTH  = 3'd1,
    REG_HEIGHT = 3'd2,
    REG_ORG_X  = 3'd3,
    REG_ORG_Y  = 3'd4,
    REG_ORG_Z  = 3'd5,
    REG_SCALE  = 3'd6
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_IDX,
    ST_READ,
    ST_WRITE
  } state_e;

  // Effective configuration: sizes clamped, scale never zero
  typedef struct packed {
    logic [LEN_W-1:0]        len;
    logic [WID_W-1:0]        wid;
    logic [HGT_W-1:0]        hgt;
    logic signed [POS_W-1:0] org_x;
    logic signed [POS_W-1:0] org_y;
    logic signed [POS_W-1:0] org_z;
    logic [SCALE_W-1:0]      scale;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic clear_wr;
    logic mul_en;
    logic idx_en;
    logic rd_en;
    logic wr_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic clear_last;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

### hdl/vog_if.sv
// Valid/ready channel interfaces for the item input and result output.
// Depends on vog_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface vog_in_if;
  logic                              valid;
  logic                              ready;
  logic [vog_pkg::ACT_W-1:0]         action;
  logic signed [vog_pkg::POS_W-1:0]  pos_x;
  logic signed [vog_pkg::POS_W-1:0]  pos_y;
  logic signed [vog_pkg::POS_W-1:0]  pos_z;
  logic signed [vog_pkg::QCELL_W-1:0] query_cell_x;
  logic signed [vog_pkg::QCELL_W-1:0] query_cell_y;
  logic signed [vog_pkg::QCELL_W-1:0] query_cell_z;

  modport source (
    output valid, action, pos_x, pos_y, pos_z, query_cell_x, query_cell_y, query_cell_z,
    input  ready
  );
  modport sink (
    input  valid, action, pos_x, pos_y, pos_z, query_cell_x, query_cell_y, query_cell_z,
    output ready
  );
endinterface

interface vog_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  occupied;
  logic                                  in_grid;
  logic signed [vog_pkg::OUT_CELL_W-1:0] cell_x;
  logic signed [vog_pkg::OUT_CELL_W-1:0] cell_y;
  logic signed [vog_pkg::OUT_CELL_W-1:0] cell_z;
  logic [vog_pkg::LIN_W-1:0]             linear_index;

  modport source (
    output valid, occupied, in_grid, cell_x, cell_y, cell_z, linear_index,
    input  ready
  );
  modport sink (
    input  valid, occupied, in_grid, cell_x, cell_y, cell_z, linear_index,
    output ready
  );
endinterface

`default_nettype wire

### hdl/voxel_occupancy_grid.sv
// Voxel occupancy grid, top level.
// The controller takes one item at a time and walks it through scale multiply, index
// multiply, store read and write back before it takes the next; the result is registered.
// A stalled output holds the write step. Reset restores the register defaults and
// starts a clearing pass over all ROWS (1024) rows of the store; no input transfer until done.
`timescale 1ns / 1ps
`default_nettype none

module voxel_occupancy_grid (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  vog_in_if.sink                            in_i,
  vog_out_if.source                         out_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [vog_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [vog_pkg::APB_DW-1:0]   pwdata,
  output logic      [vog_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);
  import vog_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  vog_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vog_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  vog_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_i   (in_i),
    .out_o  (out_o)
  );

`ifndef ASSERT_OFF
  a_no_input_while_clearing : assert property (
    @(posedge clk_i) disable iff (!rst_ni) cmd.clear_wr |-> !in_i.ready
  ) else $error("input ready during the clearing pass");

  a_one_item_in_flight : assert property (
    @(posedge clk_i) disable iff (!rst_ni) (in_i.valid && in_i.ready) |=> !in_i.ready
  ) else $error("second item taken while one is in flight");

  a_result_from_write_step : assert property (
    @(posedge clk_i) disable iff (!rst_ni) $rose(out_o.valid) |-> $past(cmd.wr_en)
  ) else $error("result valid without a write step");

  a_outside_is_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (out_o.valid && !out_o.in_grid) |-> (!out_o.occupied && out_o.linear_index == '0)
  ) else $error("out-of-grid result carries occupancy or index");
`endif

endmodule

`default_nettype wire

### hdl/vog_cfg.sv
// APB configuration registers and their effective (clamped) values.
// Depends on vog_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vog_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [vog_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [vog_pkg::APB_DW-1:0]   pwdata,
  output logic      [vog_pkg::APB_DW-1:0]   prdata,
  output logic                              pready,
  output vog_pkg::cfg_t                     cfg_o
);
  import vog_pkg::*;

  logic [CFG_LEN_W-1:0] len_q;
  logic [CFG_WID_W-1:0] wid_q;
  logic [CFG_HGT_W-1:0] hgt_q;
  logic [POS_W-1:0]     org_x_q;
  logic [POS_W-1:0]     org_y_q;
  logic [POS_W-1:0]     org_z_q;
  logic [SCALE_W-1:0]   scale_q;
  reg_e                 reg_idx;
  logic                 wr_fire;

  assign reg_idx = reg_e'(paddr[PADDR_W-1:2]);
  assign wr_fire = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= CFG_LEN_W'(RST_LENGTH);
      wid_q   <= CFG_WID_W'(RST_WIDTH);
      hgt_q   <= CFG_HGT_W'(RST_HEIGHT);
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      scale_q <= SCALE_W'(RST_SCALE);
    end else if (wr_fire) begin
      case (reg_idx)
        REG_LENGTH: len_q   <= pwdata[CFG_LEN_W-1:0];
        REG_WIDTH:  wid_q   <= pwdata[CFG_WID_W-1:0];
        REG_HEIGHT: hgt_q   <= pwdata[CFG_HGT_W-1:0];
        REG_ORG_X:  org_x_q <= pwdata[POS_W-1:0];
        REG_ORG_Y:  org_y_q <= pwdata[POS_W-1:0];
        REG_ORG_Z:  org_z_q <= pwdata[POS_W-1:0];
        REG_SCALE:  scale_q <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LENGTH: prdata = APB_DW'(len_q);
      REG_WIDTH:  prdata = APB_DW'(wid_q);
      REG_HEIGHT: prdata = APB_DW'(hgt_q);
      REG_ORG_X:  prdata = APB_DW'(org_x_q);
      REG_ORG_Y:  prdata = APB_DW'(org_y_q);
      REG_ORG_Z:  prdata = APB_DW'(org_z_q);
      REG_SCALE:  prdata = APB_DW'(scale_q);
      default:    prdata = '0;
    endcase
  end

  // Zero size counts as one, oversize counts as the limit
  always_comb begin
    if (len_q == '0)                          cfg_o.len = LEN_W'(1);
    else if (32'(len_q) > 32'(MAX_LENGTH))    cfg_o.len = LEN_W'(MAX_LENGTH);
    else                                      cfg_o.len = LEN_W'(len_q);

    if (wid_q == '0)                          cfg_o.wid = WID_W'(1);
    else if (32'(wid_q) > 32'(MAX_WIDTH))     cfg_o.wid = WID_W'(MAX_WIDTH);
    else                                      cfg_o.wid = WID_W'(wid_q);

    if (hgt_q == '0)                          cfg_o.hgt = HGT_W'(1);
    else if (32'(hgt_q) > 32'(MAX_HEIGHT))    cfg_o.hgt = HGT_W'(MAX_HEIGHT);
    else                                      cfg_o.hgt = HGT_W'(hgt_q);

    cfg_o.org_x = $signed(org_x_q);
    cfg_o.org_y = $signed(org_y_q);
    cfg_o.org_z = $signed(org_z_q);
    cfg_o.scale = (scale_q == '0) ? SCALE_W'(1) : scale_q;
  end

endmodule

`default_nettype wire

### hdl/vog_ctrl.sv
// Controller state machine: clearing sweep, then one item at a time
// through scale, index, read and write steps. Depends on vog_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vog_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vog_pkg::dp_sts_t   sts_i,
  output vog_pkg::ctrl_cmd_t      cmd_o
);
  import vog_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.idle = 1'b1;
        if (sts_i.in_fire) state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_IDX;
      end
      ST_IDX: begin
        cmd_o.idx_en = 1'b1;
        state_d      = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_WRITE;
      end
      ST_WRITE: begin
        // hold until the output register can take the result
        if (!sts_i.out_busy) begin
          cmd_o.wr_en = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### hdl/vog_dp.sv
// Datapath: position-to-cell scaling, grid test, linear index,
// occupancy store with read-modify-write, result register. Depends on vog_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vog_dp (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire vog_pkg::cfg_t       cfg_i,
  input  wire vog_pkg::ctrl_cmd_t  cmd_i,
  output vog_pkg::dp_sts_t         sts_o,
  vog_in_if.sink                   in_i,
  vog_out_if.source                out_o
);
  import vog_pkg::*;

  localparam int LW_W  = LEN_W + WID_W;
  localparam int YL_W  = YC_W + LEN_W;
  localparam int ZLW_W = ZC_W + LW_W;
  localparam logic signed [CELL_W-1:0] SAT_HI = CELL_W'(2 ** (OUT_CELL_W - 1) - 1);
  localparam logic signed [CELL_W-1:0] SAT_LO = CELL_W'(-(2 ** (OUT_CELL_W - 1)));

  function automatic logic signed [OUT_CELL_W-1:0] sat_cell(
    input logic signed [CELL_W-1:0] v
  );
    logic signed [OUT_CELL_W-1:0] r;
    if (v > SAT_HI)      r = SAT_HI[OUT_CELL_W-1:0];
    else if (v < SAT_LO) r = SAT_LO[OUT_CELL_W-1:0];
    else                 r = v[OUT_CELL_W-1:0];
    return r;
  endfunction

  // Input capture
  act_e                      action_q;
  logic signed [DIFF_W-1:0]  diff_x_q, diff_y_q, diff_z_q;
  logic signed [QCELL_W-1:0] qx_q, qy_q, qz_q;

  // Scale stage
  logic signed [PROD_W-1:0]  prod_x, prod_y, prod_z;
  logic signed [CELL_W-1:0]  cx_q, cy_q, cz_q;
  logic [LW_W-1:0]           lw_q;

  // Index stage
  logic                      inside_d, inside_q;
  logic [YL_W-1:0]           yl_q;
  logic [ZLW_W-1:0]          zlw_q;

  // Read stage
  logic [IDX_W-1:0]          idx_d;
  logic [ROW_AW-1:0]         row_d, row_q;
  logic [ROW_LOG-1:0]        bit_q;
  logic [LIN_W-1:0]          lin_q;

  // Store
  logic [ROW_BITS-1:0]       mem_q [ROWS];
  logic [ROW_BITS-1:0]       rdata_q;
  logic [ROW_BITS-1:0]       new_row;
  logic [ROW_AW-1:0]         clr_cnt_q;
  logic                      upd_we;
  logic                      mem_we;
  logic [ROW_AW-1:0]         mem_waddr;
  logic [ROW_BITS-1:0]       mem_wdata;

  // Result register
  logic                         out_valid_q;
  logic                         occ_q, in_grid_q;
  logic signed [OUT_CELL_W-1:0] ox_q, oy_q, oz_q;
  logic [LIN_W-1:0]             olin_q;

  assign in_i.ready         = cmd_i.idle;
  assign sts_o.in_fire      = in_i.valid && cmd_i.idle;
  assign sts_o.clear_last   = (32'(clr_cnt_q) == 32'(ROWS - 1));
  assign sts_o.out_busy     = out_valid_q && !out_o.ready;

  always_ff @(posedge clk_i) begin
    if (sts_o.in_fire) begin
      action_q <= act_e'(in_i.action);
      diff_x_q <= DIFF_W'(in_i.pos_x) - DIFF_W'(cfg_i.org_x);
      diff_y_q <= DIFF_W'(in_i.pos_y) - DIFF_W'(cfg_i.org_y);
      diff_z_q <= DIFF_W'(in_i.pos_z) - DIFF_W'(cfg_i.org_z);
      qx_q     <= in_i.query_cell_x;
      qy_q     <= in_i.query_cell_y;
      qz_q     <= in_i.query_cell_z;
    end
  end

  // Floor of the Q26.24 product is the arithmetic drop of the fraction bits
  assign prod_x = diff_x_q * $signed({1'b0, cfg_i.scale});
  assign prod_y = diff_y_q * $signed({1'b0, cfg_i.scale});
  assign prod_z = diff_z_q * $signed({1'b0, cfg_i.scale});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      if (action_q == ACT_QUERY_CELL) begin
        cx_q <= CELL_W'(qx_q);
        cy_q <= CELL_W'(qy_q);
        cz_q <= CELL_W'(qz_q);
      end else begin
        cx_q <= prod_x[PROD_W-1:FRAC_W];
        cy_q <= prod_y[PROD_W-1:FRAC_W];
        cz_q <= prod_z[PROD_W-1:FRAC_W];
      end
      lw_q <= LW_W'(cfg_i.len) * LW_W'(cfg_i.wid);
    end
  end

  assign inside_d = !cx_q[CELL_W-1] && ($unsigned(cx_q) < CELL_W'(cfg_i.len)) &&
                    !cy_q[CELL_W-1] && ($unsigned(cy_q) < CELL_W'(cfg_i.wid)) &&
                    !cz_q[CELL_W-1] && ($unsigned(cz_q) < CELL_W'(cfg_i.hgt));

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_en) begin
      inside_q <= inside_d;
      yl_q     <= YL_W'(cy_q[YC_W-1:0]) * YL_W'(cfg_i.len);
      zlw_q    <= ZLW_W'(cz_q[ZC_W-1:0]) * ZLW_W'(lw_q);
    end
  end

  assign idx_d = IDX_W'(cx_q[XC_W-1:0]) + IDX_W'(yl_q) + IDX_W'(zlw_q);
  assign row_d = ROW_AW'(idx_d >> ROW_LOG);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      row_q <= row_d;
      bit_q <= idx_d[ROW_LOG-1:0];
      lin_q <= inside_q ? LIN_W'(idx_d) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en && inside_q) begin
      rdata_q <= mem_q[row_d];
    end
  end

  always_comb begin
    new_row = rdata_q;
    case (action_q)
      ACT_SET:   new_row[bit_q] = 1'b1;
      ACT_CLEAR: new_row[bit_q] = 1'b0;
      default: ;
    endcase
  end

  assign upd_we    = cmd_i.wr_en && inside_q &&
                     (action_q == ACT_SET || action_q == ACT_CLEAR);
  assign mem_we    = cmd_i.clear_wr || upd_we;
  assign mem_waddr = cmd_i.clear_wr ? clr_cnt_q : row_q;
  assign mem_wdata = cmd_i.clear_wr ? '0 : new_row;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  // Sweep counter for the clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_wr) begin
      clr_cnt_q <= clr_cnt_q + ROW_AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.wr_en) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      occ_q     <= inside_q && new_row[bit_q];
      in_grid_q <= inside_q;
      ox_q      <= sat_cell(cx_q);
      oy_q      <= sat_cell(cy_q);
      oz_q      <= sat_cell(cz_q);
      olin_q    <= lin_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.occupied     = occ_q;
  assign out_o.in_grid      = in_grid_q;
  assign out_o.cell_x       = ox_q;
  assign out_o.cell_y       = oy_q;
  assign out_o.cell_z       = oz_q;
  assign out_o.linear_index = olin_q;

endmodule

`default_nettype wire
